// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define APQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked in the cycle after a trigger
`define APQ_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/apq_pkg.sv =====
// Types and constants of the array priority queue.
`timescale 1ns / 1ps

package apq_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Payload field widths
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int WORD_W  = VALUE_W + PRIO_W;

    // Stream widths
    localparam int ACT_W        = 2;
    localparam int STAT_W       = 3;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_PAD_W    = OUT_TDATA_W - WORD_W - 2;

    // Action codes; code three is served as clear
    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLR = 2'd2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_ENQUEUED  = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_DEQUEUED  = 3'd2,
        STAT_UNDERFLOW = 3'd3,
        STAT_CLEARED   = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

endpackage

// ===== hw/rtl/apq_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/array_priority_queue.sv =====
// Bounded priority queue kept in arrival order, with a scanning dequeue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Holds up to DEPTH (value, priority) entries in one RAM in arrival order.
// Enqueue, clear, overflow and underflow finish in the accept cycle and their
// result sits in the output register in the next cycle. A dequeue with N held
// entries scans all N through the single RAM read port to find the highest
// priority (oldest wins on a tie), then moves the entries behind it one place
// forward through the same port, one entry a cycle. The block takes a new
// transfer only when idle and the output register is free or being drained
// in that cycle.
module array_priority_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [apq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // item_value, item_priority
    input  logic [apq_pkg::ACT_W-1:0]          s_axis_tuser,  // action
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [apq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // out_value, out_priority,
                                                              // is_empty, is_full, zero pad
    output logic [apq_pkg::STAT_W-1:0]         m_axis_tuser   // status
);

    import apq_pkg::*;

    // Sequencer and queue state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [PRIO_W-1:0]   r_best_prio, n_best_prio;
    logic [VALUE_W-1:0]  r_best_val, n_best_val;

    // Output register
    logic                r_ovalid, n_ovalid;
    t_status             r_status, n_status;
    logic [VALUE_W-1:0]  r_oval, n_oval;
    logic [PRIO_W-1:0]   r_oprio, n_oprio;
    logic                r_empty, n_empty;
    logic                r_full, n_full;

    // RAM ports
    logic                ram_we;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    // Input decode
    logic                in_xfer;
    logic [ACT_W-1:0]    in_action;
    logic [VALUE_W-1:0]  in_value;
    logic [PRIO_W-1:0]   in_prio;
    logic [PRIO_W-1:0]   rd_prio;
    logic [VALUE_W-1:0]  rd_value;
    logic                rd_done;
    logic                load_out;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_action     = s_axis_tuser;
    assign in_value      = s_axis_tdata[VALUE_W-1:0];
    assign in_prio       = s_axis_tdata[WORD_W-1:VALUE_W];
    assign rd_value      = ram_rd_data[VALUE_W-1:0];
    assign rd_prio       = ram_rd_data[WORD_W-1:VALUE_W];
    // all reads issued and the last one consumed
    assign rd_done       = (r_rd_idx == r_count) && !r_pend;

    // Entry storage: priority in the upper bits, value in the lower
    apq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && in_action == ACT_DEQ && r_count != '0) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_done) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (rd_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and result
    always_comb begin
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend_idx  = r_pend_idx;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_best_val  = r_best_val;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_status    = r_status;
        n_oval      = r_oval;
        n_oprio     = r_oprio;
        n_empty     = r_empty;
        n_full      = r_full;
        ram_we      = 1'b0;
        ram_wr_addr = r_count[IDX_W-1:0];
        ram_wr_data = {in_prio, in_value};
        ram_re      = 1'b0;
        ram_rd_addr = r_rd_idx[IDX_W-1:0];
        load_out    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_oval  = '0;
                    n_oprio = '0;
                    unique case (in_action)
                        ACT_ENQ: begin
                            load_out = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                ram_we   = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_status = STAT_ENQUEUED;
                            end
                        end
                        ACT_DEQ: begin
                            if (r_count == '0) begin
                                load_out = 1'b1;
                                n_status = STAT_UNDERFLOW;
                            end else begin
                                n_rd_idx = '0;
                            end
                        end
                        default: begin
                            // clear, and the unused code three
                            load_out = 1'b1;
                            n_count  = '0;
                            n_status = STAT_CLEARED;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next read
                if (r_rd_idx != r_count) begin
                    ram_re     = 1'b1;
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end
                // strict greater keeps the oldest on a tie
                if (r_pend && (r_pend_idx == '0 || rd_prio > r_best_prio)) begin
                    n_best_idx  = r_pend_idx;
                    n_best_prio = rd_prio;
                    n_best_val  = rd_value;
                end
                if (rd_done) begin
                    n_rd_idx = CNT_W'(r_best_idx) + CNT_W'(1);
                end
            end
            ST_SHIFT: begin
                // read entry k, write it back at k-1 next cycle
                if (r_rd_idx != r_count) begin
                    ram_re     = 1'b1;
                    n_rd_idx   = r_rd_idx + CNT_W'(1);
                    n_pend_idx = r_rd_idx[IDX_W-1:0];
                end
                if (r_pend) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = r_pend_idx - IDX_W'(1);
                    ram_wr_data = ram_rd_data;
                end
                if (rd_done) begin
                    load_out = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                    n_status = STAT_DEQUEUED;
                    n_oval   = r_best_val;
                    n_oprio  = r_best_prio;
                end
            end
            default: ;
        endcase

        // flags follow the count after this step
        if (load_out) begin
            n_ovalid = 1'b1;
            n_empty  = (n_count == '0);
            n_full   = (n_count == CNT_W'(DEPTH));
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_pend   <= ram_re;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_best_val  <= n_best_val;
        r_status    <= n_status;
        r_oval      <= n_oval;
        r_oprio     <= n_oprio;
        r_empty     <= n_empty;
        r_full      <= n_full;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_full, r_empty, r_oprio, r_oval};

    // Checks
    `APQ_ASSERT(a_count_bound, (r_count <= CNT_W'(DEPTH)), "entry count above depth")
    `APQ_ASSERT(a_flags_match,
                r_ovalid |-> (r_empty == (r_count == '0) &&
                              r_full == (r_count == CNT_W'(DEPTH))),
                "result flags disagree with count")
    `APQ_ASSERT(a_busy_no_result, (r_state != ST_IDLE) |-> !r_ovalid, "result pending during dequeue")
    `APQ_ASSERT_NEXT(a_deq_count, r_state == ST_SHIFT && rd_done,
                     r_count == $past(r_count) - CNT_W'(1),
                     "dequeue did not remove one entry")

endmodule
